@@ hdl/fcst_pkg.sv @@
// Shared types and constants for the FOC current-sense transform block.
// Used by fcst_ctrl, fcst_datapath and the top level; no dependencies.
package fcst_pkg;

   localparam int ADC_WIDTH_DEF        = 12;
   localparam int SINE_TABLE_DEPTH_DEF = 512;

   // 1/sqrt3 and 2/sqrt3 in Q16
   localparam int INV_SQRT3_Q16     = 37837;
   localparam int TWO_INV_SQRT3_Q16 = 75674;

   localparam logic [15:0] QUARTER_TURN = 16'd16384;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_CU_SCALE,
      MUL_CV_SCALE,
      MUL_ANG_SIN,
      MUL_ANG_COS,
      MUL_IU_K1,
      MUL_IV_K2,
      MUL_INTERP,
      MUL_ALPHA_COS,
      MUL_BETA_SIN,
      MUL_BETA_COS,
      MUL_ALPHA_SIN,
      MUL_FILT_D,
      MUL_FILT_Q
   } mul_op_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_IU,
      WB_IV,
      WB_BETA,
      WB_SIN,
      WB_COS,
      WB_D,
      WB_Q,
      WB_FD,
      WB_FQ
   } wb_op_type;

   typedef enum logic [1:0] {
      TBL_NONE,
      TBL_INDEX,
      TBL_READ_A,
      TBL_READ_B
   } tbl_op_type;

   typedef struct packed {
      logic       load;
      logic       out_load;
      mul_op_type mul_op;
      acc_op_type acc_op;
      wb_op_type  wb_op;
      tbl_op_type tbl_op;
   } ctrl_cmd_type;

endpackage

@@ hdl/fcst_sine_rom.sv @@
// Quarter-wave sine table, built at elaboration, with symmetry lookup.
// Standalone; instantiated by fcst_datapath.
module fcst_sine_rom #(
   parameter int SINE_TABLE_DEPTH = 512
) (
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
   output logic signed [15:0]                  data
);

   typedef longint unsigned u64_type;

   localparam int      IDX_W       = $clog2(SINE_TABLE_DEPTH);
   localparam int      HALF        = SINE_TABLE_DEPTH / 2;
   localparam int      QUARTER     = SINE_TABLE_DEPTH / 4;
   localparam int      QW          = $clog2(QUARTER + 1);
   localparam u64_type HALF_PI_Q30 = 64'd1686629713;

   // Q30 Taylor series of sin(x), terms up to x^15
   function automatic logic [14:0] quarter_sine(input u64_type x);
      u64_type x2;
      u64_type term;
      u64_type v;
      longint  sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      v = (u64_type'(sum) * 64'd32767 + (u64_type'(1) << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

   logic [14:0]      qrom [QUARTER+1];
   logic             upper;
   logic [IDX_W-1:0] kk;
   logic [QW-1:0]    qi;
   logic [14:0]      mag;

   for (genvar j = 0; j <= QUARTER; j++) begin : g_quarter
      localparam u64_type XQ = (u64_type'(j) * HALF_PI_Q30 + u64_type'(QUARTER / 2))
                               / u64_type'(QUARTER);
      assign qrom[j] = quarter_sine(XQ);
   end

   always_comb begin
      upper = (addr >= IDX_W'(HALF));
      kk    = upper ? (addr - IDX_W'(HALF)) : addr;
      qi    = (kk <= IDX_W'(QUARTER)) ? QW'(kk) : QW'(IDX_W'(HALF) - kk);
      mag   = qrom[qi];
      data  = upper ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

endmodule

@@ hdl/fcst_datapath.sv @@
// Datapath: one shared 18x18 multiplier, accumulator, working registers,
// filter state and result registers. Depends on fcst_pkg and fcst_sine_rom.
module fcst_datapath #(
   parameter int ADC_WIDTH        = 12,
   parameter int SINE_TABLE_DEPTH = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fcst_pkg::ctrl_cmd_type     cmd,
   input  logic [ADC_WIDTH-1:0]       raw_u,
   input  logic [ADC_WIDTH-1:0]       raw_v,
   input  logic [15:0]                rotor_angle,
   input  logic [15:0]                current_scale,
   input  logic [15:0]                filter_weight,
   output logic signed [15:0]         phase_u_current,
   output logic signed [15:0]         phase_v_current,
   output logic signed [15:0]         direct_current,
   output logic signed [15:0]         quadrature_current
);

   import fcst_pkg::*;

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam logic [ADC_WIDTH+1:0] FULL_SCALE = {2'b00, {ADC_WIDTH{1'b1}}};

   function automatic logic signed [37:0] round_sra16(input logic signed [37:0] v);
      return (v + 38'sd32768) >>> 16;
   endfunction

   function automatic logic signed [37:0] round_sra15(input logic signed [37:0] v);
      return (v + 38'sd16384) >>> 15;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
      logic signed [15:0] r;
      if (v > 38'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -38'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic [ADC_WIDTH-1:0]    raw_u_ff, raw_v_ff;
   logic [15:0]             angle_ff;
   logic signed [15:0]      iu_ff, iv_ff;
   logic signed [17:0]      beta_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [15:0]             frac_ff;
   logic signed [15:0]      tbl_a_ff, tbl_b_ff;
   logic signed [15:0]      sin_ff, cos_ff;
   logic signed [15:0]      d_ff, q_ff;
   logic signed [15:0]      fd_ff, fq_ff;
   logic signed [35:0]      prod_ff;
   logic signed [37:0]      acc_ff;
   logic signed [15:0]      out_u_ff, out_v_ff, out_d_ff, out_q_ff;

   logic signed [15:0]      fd_in, fq_in;
   logic signed [37:0]      acc_in;
   logic signed [35:0]      prod_in;
   logic signed [17:0]      mul_a, mul_b;
   logic signed [ADC_WIDTH+1:0] cent_u, cent_v;
   logic signed [16:0]      tbl_diff, fd_diff, fq_diff;
   logic [15:0]             angle_cos;
   logic signed [37:0]      rnd16, rnd15, prod_ext;
   logic [IDX_W-1:0]        idx_next, rom_addr;
   logic signed [15:0]      rom_data;

   assign cent_u    = $signed({1'b0, raw_u_ff, 1'b0}) - $signed(FULL_SCALE);
   assign cent_v    = $signed({1'b0, raw_v_ff, 1'b0}) - $signed(FULL_SCALE);
   assign tbl_diff  = 17'(tbl_b_ff) - 17'(tbl_a_ff);
   assign fd_diff   = 17'(d_ff) - 17'(fd_ff);
   assign fq_diff   = 17'(q_ff) - 17'(fq_ff);
   assign angle_cos = angle_ff + QUARTER_TURN;
   assign prod_ext  = 38'(prod_ff);
   assign rnd16     = round_sra16(acc_ff);
   assign rnd15     = round_sra15(acc_ff);
   assign idx_next  = (idx_ff == IDX_W'(SINE_TABLE_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
   assign rom_addr  = (cmd.tbl_op == TBL_READ_B) ? idx_next : idx_ff;

   fcst_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .addr (rom_addr),
      .data (rom_data)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         MUL_CU_SCALE: begin
            mul_a = 18'(cent_u);
            mul_b = $signed({2'b00, current_scale});
         end
         MUL_CV_SCALE: begin
            mul_a = 18'(cent_v);
            mul_b = $signed({2'b00, current_scale});
         end
         MUL_ANG_SIN: begin
            mul_a = $signed({2'b00, angle_ff});
            mul_b = 18'(SINE_TABLE_DEPTH);
         end
         MUL_ANG_COS: begin
            mul_a = $signed({2'b00, angle_cos});
            mul_b = 18'(SINE_TABLE_DEPTH);
         end
         MUL_IU_K1: begin
            mul_a = 18'(iu_ff);
            mul_b = 18'(INV_SQRT3_Q16);
         end
         MUL_IV_K2: begin
            mul_a = 18'(iv_ff);
            mul_b = 18'(TWO_INV_SQRT3_Q16);
         end
         MUL_INTERP: begin
            mul_a = 18'(tbl_diff);
            mul_b = $signed({2'b00, frac_ff});
         end
         MUL_ALPHA_COS: begin
            mul_a = 18'(iu_ff);
            mul_b = 18'(cos_ff);
         end
         MUL_BETA_SIN: begin
            mul_a = beta_ff;
            mul_b = 18'(sin_ff);
         end
         MUL_BETA_COS: begin
            mul_a = beta_ff;
            mul_b = 18'(cos_ff);
         end
         MUL_ALPHA_SIN: begin
            mul_a = 18'(iu_ff);
            mul_b = 18'(sin_ff);
         end
         MUL_FILT_D: begin
            mul_a = 18'(fd_diff);
            mul_b = $signed({2'b00, filter_weight});
         end
         MUL_FILT_Q: begin
            mul_a = 18'(fq_diff);
            mul_b = $signed({2'b00, filter_weight});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   always_comb begin
      fd_in = fd_ff;
      fq_in = fq_ff;
      if (cmd.wb_op == WB_FD) begin
         fd_in = sat16(38'(fd_ff) + rnd16);
      end
      if (cmd.wb_op == WB_FQ) begin
         fq_in = sat16(38'(fq_ff) + rnd16);
      end
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         fd_ff <= '0;
         fq_ff <= '0;
      end else begin
         fd_ff <= fd_in;
         fq_ff <= fq_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.load) begin
         raw_u_ff <= raw_u;
         raw_v_ff <= raw_v;
         angle_ff <= rotor_angle;
      end
      case (cmd.wb_op)
         WB_IU:   iu_ff   <= sat16(rnd16);
         WB_IV:   iv_ff   <= sat16(rnd16);
         WB_BETA: beta_ff <= rnd16[17:0];
         WB_SIN:  sin_ff  <= tbl_a_ff + rnd16[15:0];
         WB_COS:  cos_ff  <= tbl_a_ff + rnd16[15:0];
         WB_D:    d_ff    <= sat16(rnd15);
         WB_Q:    q_ff    <= sat16(rnd15);
         default: ;
      endcase
      case (cmd.tbl_op)
         TBL_INDEX: begin
            idx_ff  <= prod_ff[16 +: IDX_W];
            frac_ff <= prod_ff[15:0];
         end
         TBL_READ_A: tbl_a_ff <= rom_data;
         TBL_READ_B: tbl_b_ff <= rom_data;
         default: ;
      endcase
      if (cmd.out_load) begin
         out_u_ff <= iu_ff;
         out_v_ff <= iv_ff;
         out_d_ff <= fd_ff;
         out_q_ff <= fq_ff;
      end
   end

   assign phase_u_current    = out_u_ff;
   assign phase_v_current    = out_v_ff;
   assign direct_current     = out_d_ff;
   assign quadrature_current = out_q_ff;

endmodule

@@ hdl/fcst_ctrl.sv @@
// Sequencer: input/output handshakes and the per-step datapath commands.
// Depends on fcst_pkg.
module fcst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output fcst_pkg::ctrl_cmd_type cmd
);

   import fcst_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } state_type;

   localparam logic [4:0] LAST_STEP = 5'd21;

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;
   logic       out_load;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_OUT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // multiplier result is registered into prod in the cycle after issue
   always_comb begin
      cmd.load     = accept;
      cmd.out_load = out_load;
      cmd.mul_op   = MUL_NONE;
      cmd.acc_op   = ACC_HOLD;
      cmd.wb_op    = WB_NONE;
      cmd.tbl_op   = TBL_NONE;
      if (state_ff == ST_RUN) begin
         case (step_ff)
            5'd0: cmd.mul_op = MUL_CU_SCALE;
            5'd1: begin
               cmd.mul_op = MUL_CV_SCALE;
               cmd.acc_op = ACC_LOAD;
            end
            5'd2: begin
               cmd.wb_op  = WB_IU;
               cmd.acc_op = ACC_LOAD;
            end
            5'd3: begin
               cmd.wb_op  = WB_IV;
               cmd.mul_op = MUL_ANG_SIN;
            end
            5'd4: begin
               cmd.tbl_op = TBL_INDEX;
               cmd.mul_op = MUL_IU_K1;
            end
            5'd5: begin
               cmd.tbl_op = TBL_READ_A;
               cmd.mul_op = MUL_IV_K2;
               cmd.acc_op = ACC_LOAD;
            end
            5'd6: begin
               cmd.tbl_op = TBL_READ_B;
               cmd.acc_op = ACC_ADD;
               cmd.mul_op = MUL_ANG_COS;
            end
            5'd7: begin
               cmd.wb_op  = WB_BETA;
               cmd.mul_op = MUL_INTERP;
               cmd.tbl_op = TBL_INDEX;
            end
            5'd8: begin
               cmd.acc_op = ACC_LOAD;
               cmd.tbl_op = TBL_READ_B;
            end
            5'd9: begin
               cmd.wb_op  = WB_SIN;
               cmd.tbl_op = TBL_READ_A;
            end
            5'd10: cmd.mul_op = MUL_INTERP;
            5'd11: cmd.acc_op = ACC_LOAD;
            5'd12: cmd.wb_op  = WB_COS;
            5'd13: cmd.mul_op = MUL_ALPHA_COS;
            5'd14: begin
               cmd.mul_op = MUL_BETA_SIN;
               cmd.acc_op = ACC_LOAD;
            end
            5'd15: begin
               cmd.mul_op = MUL_BETA_COS;
               cmd.acc_op = ACC_ADD;
            end
            5'd16: begin
               cmd.mul_op = MUL_ALPHA_SIN;
               cmd.wb_op  = WB_D;
               cmd.acc_op = ACC_LOAD;
            end
            5'd17: begin
               cmd.acc_op = ACC_SUB;
               cmd.mul_op = MUL_FILT_D;
            end
            5'd18: begin
               cmd.wb_op  = WB_Q;
               cmd.acc_op = ACC_LOAD;
            end
            5'd19: begin
               cmd.wb_op  = WB_FD;
               cmd.mul_op = MUL_FILT_Q;
            end
            5'd20: cmd.acc_op = ACC_LOAD;
            5'd21: cmd.wb_op  = WB_FQ;
            default: cmd.mul_op = MUL_NONE;
         endcase
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN && step_ff == 5'd0))
      else $error("accepted word did not start the sequence");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= LAST_STEP))
      else $error("step counter past last step");

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_ff == LAST_STEP) |=> (state_ff == ST_OUT))
      else $error("sequence end did not reach output state");

   a_out_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result load without valid");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_OUT))
      else $error("result overwritten while stalled");

endmodule

@@ hdl/foc_current_sense_transform_unit.sv @@
// FOC current-sense transform: phase scaling, Clarke/Park, d/q low-pass.
// Top level; depends on fcst_pkg, fcst_ctrl, fcst_datapath, fcst_sine_rom.
//
// Usage:
//   req channel: one word per PWM period with two phase ADC samples and the
//   electrical rotor angle. rsp channel: one word per request with the two
//   scaled phase currents and the filtered d and q currents (Q5.10).
//   csr port: current_scale at 0x0, filter_weight at 0x4; write only while
//   no request is in flight. Reads return the register value.
// Sequence:
//   A request runs as the 22-step sequence on the single shared 18x18
//   multiplier; its result shows on rsp_tvalid once the sequence ends and
//   the output slot is free. A new request is not taken before that.
//   req_tready is high only between requests.
// Reset: synchronous; clears the filter state, loads register defaults
//   (current_scale 1024, filter_weight 6554) and drops rsp_tvalid.
// Stall: the result waits in the output register; the next request is
//   still taken and processed, then holds at completion until the earlier
//   result is taken.
module foc_current_sense_transform_unit #(
   parameter int ADC_WIDTH        = fcst_pkg::ADC_WIDTH_DEF,
   parameter int SINE_TABLE_DEPTH = fcst_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // raw_u, raw_v, rotor_angle[15:0], zero padding
   input  logic [8*((2*ADC_WIDTH+23)/8)-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // phase_u_current, phase_v_current, direct_current, quadrature_current
   output logic [63:0]                            rsp_tdata,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [2:0]                             csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   import fcst_pkg::*;

   localparam logic REG_CURRENT_SCALE = 1'b0;
   localparam logic REG_FILTER_WEIGHT = 1'b1;

   ctrl_cmd_type       cmd;
   logic [15:0]        scale_ff, scale_in;
   logic [15:0]        weight_ff, weight_in;
   logic               csr_write;
   logic signed [15:0] phase_u_current, phase_v_current;
   logic signed [15:0] direct_current, quadrature_current;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      scale_in  = scale_ff;
      weight_in = weight_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_CURRENT_SCALE: scale_in  = csr_pwdata[15:0];
            REG_FILTER_WEIGHT: weight_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= 16'd1024;
         weight_ff <= 16'd6554;
      end else begin
         scale_ff  <= scale_in;
         weight_ff <= weight_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_CURRENT_SCALE: csr_prdata = {16'd0, scale_ff};
         REG_FILTER_WEIGHT: csr_prdata = {16'd0, weight_ff};
         default:           csr_prdata = '0;
      endcase
   end

   fcst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fcst_datapath #(
      .ADC_WIDTH        (ADC_WIDTH),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .raw_u              (req_tdata[ADC_WIDTH-1:0]),
      .raw_v              (req_tdata[2*ADC_WIDTH-1:ADC_WIDTH]),
      .rotor_angle        (req_tdata[2*ADC_WIDTH+15:2*ADC_WIDTH]),
      .current_scale      (scale_ff),
      .filter_weight      (weight_ff),
      .phase_u_current    (phase_u_current),
      .phase_v_current    (phase_v_current),
      .direct_current     (direct_current),
      .quadrature_current (quadrature_current)
   );

   assign rsp_tdata = {quadrature_current, direct_current, phase_v_current, phase_u_current};

endmodule
